// File: rtl/banked_register_file_top_macros.svh
// Assertion macros for the banked register file. The enclosing module must
// provide clk and rst_n.
`ifndef BANKED_REGISTER_FILE_TOP_MACROS_SVH
`define BANKED_REGISTER_FILE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define BRF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("brf assertion failed");

// cond must never be true outside reset
`define BRF_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("brf forbidden condition seen");

`else

`define BRF_ASSERT(label, prop)
`define BRF_NEVER(label, cond)

`endif

`endif

// File: rtl/brf_pkg.sv
`default_nettype none

package brf_pkg;

  localparam int DataW = 32;
  localparam int IdxW  = 5;
  localparam int ModeW = 5;
  localparam int InW   = 48;  // 43 payload bits padded to whole bytes
  localparam int OutW  = 40;

  localparam int NumCommon    = 16;
  localparam int NumFiq       = 5;
  localparam int NumStackLink = 10;
  localparam int NumExcBanks  = 5;

  localparam logic [ModeW-1:0] MODE_USR = 5'h10;
  localparam logic [ModeW-1:0] MODE_FIQ = 5'h11;
  localparam logic [ModeW-1:0] MODE_IRQ = 5'h12;
  localparam logic [ModeW-1:0] MODE_SVC = 5'h13;
  localparam logic [ModeW-1:0] MODE_ABT = 5'h17;
  localparam logic [ModeW-1:0] MODE_UND = 5'h1B;
  localparam logic [ModeW-1:0] MODE_SYS = 5'h1F;

  localparam logic [IdxW-1:0] IDX_R8   = 5'd8;
  localparam logic [IdxW-1:0] IDX_R12  = 5'd12;
  localparam logic [IdxW-1:0] IDX_SP   = 5'd13;
  localparam logic [IdxW-1:0] IDX_LR   = 5'd14;
  localparam logic [IdxW-1:0] IDX_CPSR = 5'd16;
  localparam logic [IdxW-1:0] IDX_SPSR = 5'd17;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    BANK_SVC  = 3'd0,
    BANK_ABT  = 3'd1,
    BANK_UND  = 3'd2,
    BANK_IRQ  = 3'd3,
    BANK_FIQ  = 3'd4,
    BANK_NONE = 3'd7
  } bank_t;

  typedef struct packed {
    logic             op;
    logic [IdxW-1:0]  reg_index;
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [ModeW-1:0] current_mode;
    logic             current_has_spsr;
    logic             privileged;
    logic             spsr_absent;
  } resp_t;

  // exception bank of a mode; user, system and unknown codes have none
  function automatic bank_t exc_bank(logic [ModeW-1:0] mode);
    bank_t b;
    case (mode)
      MODE_SVC: b = BANK_SVC;
      MODE_ABT: b = BANK_ABT;
      MODE_UND: b = BANK_UND;
      MODE_IRQ: b = BANK_IRQ;
      MODE_FIQ: b = BANK_FIQ;
      default:  b = BANK_NONE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/brf_regfile.sv
`default_nettype none

module brf_regfile (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc_en,
  input  wire brf_pkg::req_t req,
  output brf_pkg::resp_t     resp
);

  logic [brf_pkg::DataW-1:0] common_r [brf_pkg::NumCommon];
  logic [brf_pkg::DataW-1:0] fiq_r    [brf_pkg::NumFiq];
  logic [brf_pkg::DataW-1:0] sl_r     [brf_pkg::NumStackLink];
  logic [brf_pkg::DataW-1:0] spsr_r   [brf_pkg::NumExcBanks];
  logic [brf_pkg::DataW-1:0] cpsr_r;

  brf_pkg::bank_t            bank;
  brf_pkg::bank_t            cur_bank;
  logic                      is_wr;
  logic                      is_gp;
  logic                      is_fiq_hi;
  logic                      is_sl;
  logic                      is_cpsr;
  logic                      is_spsr;
  logic                      spsr_absent;
  logic [2:0]                fiq_idx;
  logic [3:0]                gp_idx;
  logic [3:0]                sl_idx;
  logic [2:0]                spsr_idx;
  logic [brf_pkg::DataW-1:0] rd;
  logic [brf_pkg::DataW-1:0] cpsr_after;

  always_comb begin
    bank      = brf_pkg::exc_bank(req.mode);
    is_wr     = (req.op == brf_pkg::OP_WRITE);
    is_gp     = !req.reg_index[4];
    gp_idx    = req.reg_index[3:0];
    is_fiq_hi = is_gp && (req.reg_index >= brf_pkg::IDX_R8) &&
                (req.reg_index <= brf_pkg::IDX_R12) && (bank == brf_pkg::BANK_FIQ);
    is_sl     = is_gp && ((req.reg_index == brf_pkg::IDX_SP) ||
                (req.reg_index == brf_pkg::IDX_LR)) && (bank != brf_pkg::BANK_NONE);
    is_cpsr   = (req.reg_index == brf_pkg::IDX_CPSR);
    is_spsr   = (req.reg_index == brf_pkg::IDX_SPSR) && (bank != brf_pkg::BANK_NONE);
    spsr_absent = (req.reg_index == brf_pkg::IDX_SPSR) && (bank == brf_pkg::BANK_NONE);
    fiq_idx   = 3'(req.reg_index[3:0] - 4'd8);
    // two entries per bank: R13 then R14
    sl_idx    = {bank, req.reg_index == brf_pkg::IDX_LR};
    spsr_idx  = bank;
  end

  always_comb begin
    rd = '0;
    if (is_fiq_hi) begin
      rd = fiq_r[fiq_idx];
    end else if (is_sl) begin
      rd = sl_r[sl_idx];
    end else if (is_gp) begin
      rd = common_r[gp_idx];
    end else if (is_cpsr) begin
      rd = cpsr_r;
    end else if (is_spsr) begin
      rd = spsr_r[spsr_idx];
    end
  end

  // status fields reflect a CPSR write made by this same request
  always_comb begin
    cpsr_after = (is_wr && is_cpsr) ? req.write_value : cpsr_r;
    cur_bank   = brf_pkg::exc_bank(cpsr_after[brf_pkg::ModeW-1:0]);
    resp.read_data        = is_wr ? '0 : rd;
    resp.current_mode     = cpsr_after[brf_pkg::ModeW-1:0];
    resp.current_has_spsr = (cur_bank != brf_pkg::BANK_NONE);
    resp.privileged       = (cpsr_after[brf_pkg::ModeW-1:0] != brf_pkg::MODE_USR);
    resp.spsr_absent      = spsr_absent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < brf_pkg::NumCommon; i++) common_r[i] <= '0;
      for (int i = 0; i < brf_pkg::NumFiq; i++) fiq_r[i] <= '0;
      for (int i = 0; i < brf_pkg::NumStackLink; i++) sl_r[i] <= '0;
      for (int i = 0; i < brf_pkg::NumExcBanks; i++) spsr_r[i] <= '0;
      cpsr_r <= '0;
    end else if (acc_en && is_wr) begin
      if (is_fiq_hi) begin
        fiq_r[fiq_idx] <= req.write_value;
      end else if (is_sl) begin
        sl_r[sl_idx] <= req.write_value;
      end else if (is_gp) begin
        common_r[gp_idx] <= req.write_value;
      end else if (is_cpsr) begin
        cpsr_r <= req.write_value;
      end else if (is_spsr) begin
        spsr_r[spsr_idx] <= req.write_value;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/banked_register_file_top.sv
// Banked register file: 37 physical 32-bit registers seen through a 5-bit
// processor mode. One request (read or write of logical register 0-17) is
// taken per clock unless the output stalls; it passes through the input
// register, then bank decode, register access and the result register.
// Writes take effect when the request leaves the input register, so a
// following request always sees them. Results come back in request order,
// one per request. All physical registers are zero after reset.
`default_nettype none

`include "banked_register_file_top_macros.svh"

module banked_register_file_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // op[0], reg_index[5:1], mode[10:6], write_value[42:11], zero [47:43]
  input  wire logic [brf_pkg::InW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // read_data[31:0], current_mode[36:32], current_has_spsr[37],
  // privileged[38], spsr_absent[39]
  output logic [brf_pkg::OutW-1:0]       out_tdata
);

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  brf_pkg::req_t  s1_req_r;
  logic           out_valid_r;
  logic           out_valid_nxt;
  brf_pkg::resp_t out_resp_r;
  brf_pkg::resp_t resp;
  brf_pkg::req_t  in_req;
  logic           advance;
  logic           in_fire;

  always_comb begin
    in_req.op          = in_tdata[0];
    in_req.reg_index   = in_tdata[5:1];
    in_req.mode        = in_tdata[10:6];
    in_req.write_value = in_tdata[42:11];
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);
  end

  brf_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (advance),
    .req    (s1_req_r),
    .resp   (resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (advance) begin
      out_resp_r <= resp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_resp_r.spsr_absent, out_resp_r.privileged,
                       out_resp_r.current_has_spsr, out_resp_r.current_mode,
                       out_resp_r.read_data};

  `BRF_ASSERT(a_write_reads_zero,
    advance && (s1_req_r.op == brf_pkg::OP_WRITE) |=> (out_resp_r.read_data == '0))
  `BRF_ASSERT(a_held_request_stable,
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_req_r))
  `BRF_ASSERT(a_advance_fills_output, advance |=> out_valid_r)
  `BRF_ASSERT(a_spsr_implies_priv,
    out_valid_r && out_resp_r.current_has_spsr |-> out_resp_r.privileged)
  `BRF_ASSERT(a_priv_matches_mode,
    out_valid_r |-> (out_resp_r.privileged ==
                     (out_resp_r.current_mode != brf_pkg::MODE_USR)))
  `BRF_NEVER(n_absent_with_data,
    out_valid_r && out_resp_r.spsr_absent && (out_resp_r.read_data != '0))

endmodule

`default_nettype wire
